// ===== rtl/core/ccbs_pkg.sv =====
// Shared types, constants and weight functions for the closed cubic B-spline sampler.
package ccbs_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned DEF_SAMPLE_STEPS = 20;
  localparam int unsigned DEF_COORD_BITS   = 12;

  // Fixed field widths of the two channels.
  localparam int unsigned POINT_W  = 12;
  localparam int unsigned SAMPLE_W = 16;

  // Number of stored points in the sliding window.
  localparam logic [1:0] WIN_FULL = 2'd3;

  typedef struct packed {
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
    logic               restart;
  } in_beat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic                segment_last;
  } out_beat_t;

  // Basis weights of step k out of n, scaled by 6*n^3. All are non-negative for k <= n.
  function automatic int unsigned weight_b0(int unsigned n, int unsigned k);
    int unsigned nk;
    nk = n - k;
    return nk * nk * nk;
  endfunction

  function automatic int unsigned weight_b1(int unsigned n, int unsigned k);
    return (3 * k * k * k + 4 * n * n * n) - 6 * k * k * n;
  endfunction

  function automatic int unsigned weight_b2(int unsigned n, int unsigned k);
    return (3 * k * k * n + 3 * k * n * n + n * n * n) - 3 * k * k * k;
  endfunction

  function automatic int unsigned weight_b3(int unsigned n, int unsigned k);
    return k * k * k;
  endfunction

endpackage

// ===== rtl/core/ccbs_div.sv =====
// Constant divider by reciprocal multiplication that scales blended sums to rounded sixteenths.
module ccbs_div #(
  parameter int unsigned SAMPLE_STEPS = ccbs_pkg::DEF_SAMPLE_STEPS,
  parameter int unsigned SUM_W        = 38
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic                in_last,
  input  logic [SUM_W-1:0]    sum_x,
  input  logic [SUM_W-1:0]    sum_y,
  output logic                out_valid,
  output ccbs_pkg::out_beat_t out_beat
);

  // Number of trailing zero bits of a constant.
  function automatic int unsigned low_zeros(longint unsigned v);
    int unsigned     c;
    longint unsigned r;
    c = 0;
    r = v;
    while ((r != 0) && (r[0] == 1'b0)) begin
      r = r >> 1;
      c++;
    end
    return c;
  endfunction

  localparam longint unsigned N3   = longint'(SAMPLE_STEPS) * SAMPLE_STEPS * SAMPLE_STEPS;
  localparam longint unsigned DEN  = 6 * N3;
  localparam longint unsigned HALF = 3 * N3;
  localparam int unsigned     DW   = $clog2(DEN + 1);
  localparam int unsigned     QW   = ccbs_pkg::SAMPLE_W;
  localparam int unsigned     NW   = (SUM_W + 5 > DW + QW + 1) ? SUM_W + 5 : DW + QW + 1;
  localparam logic [NW-1:0]   DEN_TOP = NW'(DEN) << QW;

  // The power-of-two part of the divisor is a shift; the odd part uses a reciprocal.
  localparam int unsigned     TZ    = low_zeros(DEN);
  localparam longint unsigned DODD  = DEN >> TZ;
  localparam int unsigned     CW    = $clog2(DODD);
  localparam int unsigned     RS    = QW + 2 * CW;
  localparam longint unsigned RECIP = ((64'd1 << RS) + DODD - 64'd1) / DODD;
  localparam int unsigned     MW    = $clog2(RECIP + 1);
  localparam int unsigned     AW    = QW + CW;
  localparam int unsigned     PRW   = AW + MW;
  localparam logic [MW-1:0]   RECIP_M = MW'(RECIP);

  logic [NW-1:0]  num_x, num_y;
  logic [AW-1:0]  a_x_r, a_y_r, a_x_nxt, a_y_nxt;
  logic           sat_x_r, sat_y_r, sat_x_nxt, sat_y_nxt;
  logic [PRW-1:0] prod_x, prod_y;
  logic [QW-1:0]  q_x_r, q_y_r, q_x_nxt, q_y_nxt;
  logic           vld1_r, vld2_r;
  logic           last1_r, last2_r;

  // Rounded numerator, overflow check and removal of the power-of-two factor.
  always_comb begin
    num_x     = (NW'(sum_x) << 4) + NW'(HALF);
    num_y     = (NW'(sum_y) << 4) + NW'(HALF);
    sat_x_nxt = (num_x >= DEN_TOP);
    sat_y_nxt = (num_y >= DEN_TOP);
    a_x_nxt   = AW'(num_x >> TZ);
    a_y_nxt   = AW'(num_y >> TZ);
  end

  // Quotient by the odd part; samples past the 16-bit range clamp to full scale.
  always_comb begin
    prod_x  = PRW'(a_x_r) * PRW'(RECIP_M);
    prod_y  = PRW'(a_y_r) * PRW'(RECIP_M);
    q_x_nxt = sat_x_r ? '1 : QW'(prod_x >> RS);
    q_y_nxt = sat_y_r ? '1 : QW'(prod_y >> RS);
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r   <= a_x_nxt;
      a_y_r   <= a_y_nxt;
      sat_x_r <= sat_x_nxt;
      sat_y_r <= sat_y_nxt;
      last1_r <= in_last;
      q_x_r   <= q_x_nxt;
      q_y_r   <= q_y_nxt;
      last2_r <= last1_r;
    end
  end

  assign out_valid             = vld2_r;
  assign out_beat.sample_x     = q_x_r;
  assign out_beat.sample_y     = q_y_r;
  assign out_beat.segment_last = last2_r;

endmodule

// ===== rtl/core/closed_cubic_bspline_sampler_core.sv =====
// Top level of the closed cubic B-spline sampler: point window, sample sequencer and datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    ccbs_pkg::in_beat_t   (one control point)
//   out      output     out_valid / out_ready  ccbs_pkg::out_beat_t  (one curve sample)
//
// A point that only fills the window gives no beat.
// A point that completes four points gives SAMPLE_STEPS + 1 beats, issued one per cycle
// by the sample counter while the output is not stalled; the next point is taken at the last issue.
// After issue, a sample passes the weight, product and sum stages and two scaling stages.
// Reset (rst_n low at a clock edge) empties the window and the pipeline.
// The whole datapath stalls as one while out_valid is high and out_ready is low.
module closed_cubic_bspline_sampler_core #(
  parameter int unsigned SAMPLE_STEPS = ccbs_pkg::DEF_SAMPLE_STEPS,
  parameter int unsigned COORD_BITS   = ccbs_pkg::DEF_COORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccbs_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output ccbs_pkg::out_beat_t out_beat
);

  localparam int unsigned     KW = $clog2(SAMPLE_STEPS + 1);
  localparam int unsigned     KD = 1 << KW;
  localparam longint unsigned N3 = longint'(SAMPLE_STEPS) * SAMPLE_STEPS * SAMPLE_STEPS;
  localparam int unsigned     WW = $clog2(4 * N3 + 1);
  localparam int unsigned     CB = COORD_BITS;
  localparam int unsigned     PW = WW + CB;
  localparam int unsigned     SW = PW + 2;
  localparam logic [KW-1:0]   K_LAST = KW'(SAMPLE_STEPS);

  // Window and sequencer state.
  logic [CB-1:0] win_x_r   [0:2];
  logic [CB-1:0] win_y_r   [0:2];
  logic [CB-1:0] win_x_nxt [0:2];
  logic [CB-1:0] win_y_nxt [0:2];
  logic [CB-1:0] seg_x_r   [0:3];
  logic [CB-1:0] seg_y_r   [0:3];
  logic [CB-1:0] seg_x_nxt [0:3];
  logic [CB-1:0] seg_y_nxt [0:3];
  logic [1:0]    fill_r, fill_nxt;
  logic          busy_r, busy_nxt;
  logic [KW-1:0] k_r, k_nxt;

  // Pipeline registers ahead of the divider.
  logic          v1_r, v2_r, v3_r;
  logic          last1_r, last2_r, last3_r;
  logic [WW-1:0] w_r     [0:3];
  logic [CB-1:0] px1_r   [0:3];
  logic [CB-1:0] py1_r   [0:3];
  logic [PW-1:0] prx_r   [0:3];
  logic [PW-1:0] pry_r   [0:3];
  logic [SW-1:0] sum_x_r, sum_y_r;

  logic          en;
  logic          accept;
  logic          issue;
  logic          last_issue;
  logic [1:0]    fill_eff;
  logic [CB-1:0] px_in, py_in;

  // Basis weight tables indexed by the sample counter.
  logic [WW-1:0] w0_tab [0:KD-1];
  logic [WW-1:0] w1_tab [0:KD-1];
  logic [WW-1:0] w2_tab [0:KD-1];
  logic [WW-1:0] w3_tab [0:KD-1];

  for (genvar g = 0; g < KD; g++) begin : g_wtab
    assign w0_tab[g] = (g <= SAMPLE_STEPS) ? WW'(ccbs_pkg::weight_b0(SAMPLE_STEPS, g)) : '0;
    assign w1_tab[g] = (g <= SAMPLE_STEPS) ? WW'(ccbs_pkg::weight_b1(SAMPLE_STEPS, g)) : '0;
    assign w2_tab[g] = (g <= SAMPLE_STEPS) ? WW'(ccbs_pkg::weight_b2(SAMPLE_STEPS, g)) : '0;
    assign w3_tab[g] = (g <= SAMPLE_STEPS) ? WW'(ccbs_pkg::weight_b3(SAMPLE_STEPS, g)) : '0;
  end

  // The pipeline advances whenever the output register is empty or being drained.
  assign en         = !out_valid || out_ready;
  assign issue      = en && busy_r;
  assign last_issue = issue && (k_r == K_LAST);
  assign in_ready   = !busy_r || last_issue;
  assign accept     = in_valid && in_ready;
  assign fill_eff   = in_beat.restart ? 2'd0 : fill_r;
  assign px_in      = CB'(in_beat.point_x);
  assign py_in      = CB'(in_beat.point_y);

  // Window update and sample counter.
  always_comb begin
    win_x_nxt = win_x_r;
    win_y_nxt = win_y_r;
    seg_x_nxt = seg_x_r;
    seg_y_nxt = seg_y_r;
    fill_nxt  = fill_r;
    busy_nxt  = busy_r;
    k_nxt     = k_r;
    if (issue) begin
      k_nxt = k_r + KW'(1);
      if (k_r == K_LAST) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      if (fill_eff < ccbs_pkg::WIN_FULL) begin
        win_x_nxt[fill_eff] = px_in;
        win_y_nxt[fill_eff] = py_in;
        fill_nxt            = fill_eff + 2'd1;
      end else begin
        seg_x_nxt = '{win_x_r[0], win_x_r[1], win_x_r[2], px_in};
        seg_y_nxt = '{win_y_r[0], win_y_r[1], win_y_r[2], py_in};
        win_x_nxt = '{win_x_r[1], win_x_r[2], px_in};
        win_y_nxt = '{win_y_r[1], win_y_r[2], py_in};
        fill_nxt  = ccbs_pkg::WIN_FULL;
        busy_nxt  = 1'b1;
        k_nxt     = '0;
      end
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  // Stored points.
  always_ff @(posedge clk) begin
    win_x_r <= win_x_nxt;
    win_y_r <= win_y_nxt;
    seg_x_r <= seg_x_nxt;
    seg_y_r <= seg_y_nxt;
  end

  // Valid bits of the weight, product and sum stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Weight lookup, one multiply per point and axis, then the four-term sum.
  always_ff @(posedge clk) begin
    if (en) begin
      last1_r <= (k_r == K_LAST);
      w_r     <= '{w0_tab[k_r], w1_tab[k_r], w2_tab[k_r], w3_tab[k_r]};
      px1_r   <= seg_x_r;
      py1_r   <= seg_y_r;
      last2_r <= last1_r;
      for (int i = 0; i < 4; i++) begin
        prx_r[i] <= PW'(w_r[i]) * PW'(px1_r[i]);
        pry_r[i] <= PW'(w_r[i]) * PW'(py1_r[i]);
      end
      last3_r <= last2_r;
      sum_x_r <= SW'(prx_r[0]) + SW'(prx_r[1]) + SW'(prx_r[2]) + SW'(prx_r[3]);
      sum_y_r <= SW'(pry_r[0]) + SW'(pry_r[1]) + SW'(pry_r[2]) + SW'(pry_r[3]);
    end
  end

  // Rounded scaling to sixteenths of a pixel; its last stage is the output register.
  ccbs_div #(
    .SAMPLE_STEPS (SAMPLE_STEPS),
    .SUM_W        (SW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_last   (last3_r),
    .sum_x     (sum_x_r),
    .sum_y     (sum_y_r),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

`ifndef SYNTHESIS
  // The sample counter never runs past the last step of a segment.
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (k_r <= K_LAST))
    else $error("sample counter past last step");

  // Issuing the last sample ends the segment unless a new point is taken with it.
  a_seg_end: assert property (@(posedge clk) disable iff (!rst_n)
    (last_issue && !accept) |=> !busy_r)
    else $error("segment did not end after last sample");

  // A point arriving on a full window starts a segment at step zero.
  a_seg_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_beat.restart && (fill_r == ccbs_pkg::WIN_FULL)) |=> (busy_r && (k_r == '0)))
    else $error("full window did not start a segment");
`endif

endmodule
